@@ rtl/core/skf_pkg.sv @@
// ---------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and helper functions for the scalar Kalman filter:
// fixed-point limits, saturation helpers and the micro-op sequence.
// ---------------------------------------------------------------------------
package skf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned VAR_W     = 31;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned MAG_W     = PROD_W - FRAC_W;
  localparam int unsigned SUM_W     = DATA_W + 2;
  localparam int unsigned DIV_STEPS = DATA_W + FRAC_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned N_UOPS    = 17;
  localparam int unsigned STEP_W    = $clog2(N_UOPS);

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = word_t'((64'd1 << (DATA_W - 1)) - 64'd1);
  localparam word_t WORD_MIN = ~WORD_MAX;
  localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_W'((64'd1 << (DATA_W - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(64'd1 << (DATA_W - 1));
  localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W - DATA_W){1'b0}}, WORD_MAX};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W - DATA_W){1'b1}}, WORD_MIN};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATE_GAIN    = 3'd0,
    REG_CONTROL_GAIN  = 3'd1,
    REG_OBSERVE_GAIN  = 3'd2,
    REG_PROCESS_NOISE = 3'd3,
    REG_MEASURE_NOISE = 3'd4,
    REG_INIT_MEAN     = 3'd5,
    REG_INIT_VARIANCE = 3'd6
  } reg_idx_e;

  localparam word_t RST_STATE_GAIN   = word_t'(65536);
  localparam word_t RST_OBSERVE_GAIN = word_t'(65536);

  typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_DIV} op_e;

  typedef enum logic [3:0] {
    SRC_A, SRC_B, SRC_H, SRC_Q, SRC_R, SRC_U, SRC_Z, SRC_M,
    SRC_P, SRC_MP, SRC_PP, SRC_HP, SRC_K, SRC_T1, SRC_T2
  } src_e;

  typedef enum logic [2:0] {
    DST_T1, DST_T2, DST_MP, DST_PP, DST_HP, DST_K, DST_MN, DST_PN
  } dst_e;

  typedef struct packed {
    op_e  op;
    src_e src_a;
    src_e src_b;
    dst_e dst;
    logic clamp;   // force a negative result to zero
    logic last;
  } uop_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic mul_wb;
    logic div_step;
    logic div_wb;
    logic commit;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

  typedef struct packed {
    word_t val;
    logic  flag;
  } sat_t;

  function automatic uop_t mk_uop(op_e op, src_e a, src_e b, dst_e d, logic clamp, logic last);
    uop_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    u.clamp = clamp;
    u.last  = last;
    return u;
  endfunction

  // One filter step as a fixed micro-op sequence.
  function automatic uop_t uop_at(logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      5'd0:    u = mk_uop(OP_MUL, SRC_A,  SRC_M,  DST_T1, 1'b0, 1'b0); // a*m
      5'd1:    u = mk_uop(OP_MUL, SRC_B,  SRC_U,  DST_T2, 1'b0, 1'b0); // b*u
      5'd2:    u = mk_uop(OP_ADD, SRC_T1, SRC_T2, DST_MP, 1'b0, 1'b0); // mp
      5'd3:    u = mk_uop(OP_MUL, SRC_A,  SRC_P,  DST_T1, 1'b0, 1'b0); // a*p
      5'd4:    u = mk_uop(OP_MUL, SRC_T1, SRC_A,  DST_T1, 1'b0, 1'b0); // a*p*a
      5'd5:    u = mk_uop(OP_ADD, SRC_T1, SRC_Q,  DST_PP, 1'b1, 1'b0); // pp
      5'd6:    u = mk_uop(OP_MUL, SRC_H,  SRC_PP, DST_HP, 1'b0, 1'b0); // h*pp
      5'd7:    u = mk_uop(OP_MUL, SRC_HP, SRC_H,  DST_T1, 1'b0, 1'b0); // hp*h
      5'd8:    u = mk_uop(OP_ADD, SRC_T1, SRC_R,  DST_T2, 1'b0, 1'b0); // den
      5'd9:    u = mk_uop(OP_DIV, SRC_HP, SRC_T2, DST_K,  1'b0, 1'b0); // gain
      5'd10:   u = mk_uop(OP_MUL, SRC_H,  SRC_MP, DST_T1, 1'b0, 1'b0); // h*mp
      5'd11:   u = mk_uop(OP_SUB, SRC_Z,  SRC_T1, DST_T1, 1'b0, 1'b0); // innovation
      5'd12:   u = mk_uop(OP_MUL, SRC_K,  SRC_T1, DST_T1, 1'b0, 1'b0); // k*innov
      5'd13:   u = mk_uop(OP_ADD, SRC_MP, SRC_T1, DST_MN, 1'b0, 1'b0); // new mean
      5'd14:   u = mk_uop(OP_MUL, SRC_K,  SRC_H,  DST_T1, 1'b0, 1'b0); // k*h
      5'd15:   u = mk_uop(OP_MUL, SRC_T1, SRC_PP, DST_T1, 1'b0, 1'b0); // k*h*pp
      5'd16:   u = mk_uop(OP_SUB, SRC_PP, SRC_T1, DST_PN, 1'b1, 1'b1); // new variance
      default: u = mk_uop(OP_SUB, SRC_PP, SRC_T1, DST_PN, 1'b1, 1'b1);
    endcase
    return u;
  endfunction

  // Magnitude of a signed word as an unsigned word.
  function automatic logic [DATA_W-1:0] mag(word_t x);
    logic [DATA_W-1:0] v;
    v = x;
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  // Signed word from sign and magnitude, saturated.
  function automatic sat_t from_mag(logic neg, logic [MAG_W-1:0] m);
    sat_t r;
    r.flag = 1'b0;
    if (neg) begin
      if (m > MAG_NEG_LIM) begin
        r.val  = WORD_MIN;
        r.flag = 1'b1;
      end else begin
        r.val = word_t'(DATA_W'(0) - m[DATA_W-1:0]);
      end
    end else begin
      if (m > MAG_POS_LIM) begin
        r.val  = WORD_MAX;
        r.flag = 1'b1;
      end else begin
        r.val = word_t'(m[DATA_W-1:0]);
      end
    end
    return r;
  endfunction

  // Saturate an exact sum to the word range.
  function automatic sat_t add_sat(logic signed [SUM_W-1:0] s);
    sat_t r;
    r.flag = 1'b0;
    if (s > SUM_MAX) begin
      r.val  = WORD_MAX;
      r.flag = 1'b1;
    end else if (s < SUM_MIN) begin
      r.val  = WORD_MIN;
      r.flag = 1'b1;
    end else begin
      r.val = word_t'(s[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/skf_in_if.sv @@
// ---------------------------------------------------------------------------
// skf_in_if
// Input channel: one beat carries a control value and an observation.
// ---------------------------------------------------------------------------
interface skf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [skf_pkg::DATA_W-1:0]  control_in;
  logic signed [skf_pkg::DATA_W-1:0]  measurement;

  modport source (output valid, control_in, measurement, input ready);
  modport sink   (input valid, control_in, measurement, output ready);
endinterface

@@ rtl/core/skf_out_if.sv @@
// ---------------------------------------------------------------------------
// skf_out_if
// Result channel: one beat carries the updated estimate and a saturation flag.
// ---------------------------------------------------------------------------
interface skf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [skf_pkg::DATA_W-1:0]  est_mean;
  logic        [skf_pkg::VAR_W-1:0]   est_variance;
  logic                               saturated;

  modport source (output valid, est_mean, est_variance, saturated, input ready);
  modport sink   (input valid, est_mean, est_variance, saturated, output ready);
endinterface

@@ rtl/core/skf_cfg_if.sv @@
// ---------------------------------------------------------------------------
// skf_cfg_if
// Configuration write channel: one beat writes one register.
// ---------------------------------------------------------------------------
interface skf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [skf_pkg::CFG_IDX_W-1:0]     index;
  logic [skf_pkg::DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/skf_datapath.sv @@
// ---------------------------------------------------------------------------
// skf_datapath
// Configuration registers, filter state, working registers, one shared
// 32x32 multiplier, a saturating adder and a bit-serial restoring divider.
// ---------------------------------------------------------------------------
module skf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skf_pkg::dp_cmd_t               cmd_i,
  output skf_pkg::dp_stat_t              stat_o,
  input  logic                           cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [skf_pkg::DATA_W-1:0]     cfg_data_i,
  input  skf_pkg::word_t                 control_in_i,
  input  skf_pkg::word_t                 measurement_i,
  output skf_pkg::word_t                 est_mean_o,
  output logic [skf_pkg::VAR_W-1:0]      est_variance_o,
  output logic                           saturated_o
);

  // configuration
  skf_pkg::word_t                  a_q, b_q, h_q, init_mean_q;
  logic [skf_pkg::VAR_W-1:0]       q_q, r_q, init_var_q;
  // filter state
  skf_pkg::word_t                  mean_q, var_q;
  // working registers
  skf_pkg::word_t                  u_q, z_q, t1_q, t2_q, mp_q, pp_q, hp_q, k_q, mn_q, pn_q;
  // multiplier stage
  logic [skf_pkg::PROD_W-1:0]      prod_q;
  logic                            prod_neg_q;
  // divider
  logic [skf_pkg::MAG_W-1:0]       dvd_q;
  logic [skf_pkg::DATA_W-1:0]      rem_q;
  logic [skf_pkg::DATA_W-1:0]      den_q;
  logic                            den_pos_q, div_neg_q;
  logic [skf_pkg::DIV_CNT_W-1:0]   div_cnt_q;
  // flags
  logic                            sat_q, sat_out_q;

  skf_pkg::word_t                  op_a, op_b;
  logic [skf_pkg::DATA_W-1:0]      mag_a, mag_b;
  logic signed [skf_pkg::SUM_W-1:0] alu_sum;
  skf_pkg::sat_t                   alu_res, mul_res, div_res, wb_raw;
  skf_pkg::word_t                  wb_val;
  logic                            wb_en, is_alu;
  logic [skf_pkg::DATA_W:0]        div_tr;
  logic                            div_ge;
  logic [skf_pkg::DATA_W:0]        div_diff;

  // select operand a
  always_comb begin
    unique case (cmd_i.uop.src_a)
      skf_pkg::SRC_A:  op_a = a_q;
      skf_pkg::SRC_B:  op_a = b_q;
      skf_pkg::SRC_H:  op_a = h_q;
      skf_pkg::SRC_Q:  op_a = skf_pkg::word_t'({1'b0, q_q});
      skf_pkg::SRC_R:  op_a = skf_pkg::word_t'({1'b0, r_q});
      skf_pkg::SRC_U:  op_a = u_q;
      skf_pkg::SRC_Z:  op_a = z_q;
      skf_pkg::SRC_M:  op_a = mean_q;
      skf_pkg::SRC_P:  op_a = var_q;
      skf_pkg::SRC_MP: op_a = mp_q;
      skf_pkg::SRC_PP: op_a = pp_q;
      skf_pkg::SRC_HP: op_a = hp_q;
      skf_pkg::SRC_K:  op_a = k_q;
      skf_pkg::SRC_T1: op_a = t1_q;
      skf_pkg::SRC_T2: op_a = t2_q;
      default:         op_a = '0;
    endcase
  end

  // select operand b
  always_comb begin
    unique case (cmd_i.uop.src_b)
      skf_pkg::SRC_A:  op_b = a_q;
      skf_pkg::SRC_B:  op_b = b_q;
      skf_pkg::SRC_H:  op_b = h_q;
      skf_pkg::SRC_Q:  op_b = skf_pkg::word_t'({1'b0, q_q});
      skf_pkg::SRC_R:  op_b = skf_pkg::word_t'({1'b0, r_q});
      skf_pkg::SRC_U:  op_b = u_q;
      skf_pkg::SRC_Z:  op_b = z_q;
      skf_pkg::SRC_M:  op_b = mean_q;
      skf_pkg::SRC_P:  op_b = var_q;
      skf_pkg::SRC_MP: op_b = mp_q;
      skf_pkg::SRC_PP: op_b = pp_q;
      skf_pkg::SRC_HP: op_b = hp_q;
      skf_pkg::SRC_K:  op_b = k_q;
      skf_pkg::SRC_T1: op_b = t1_q;
      skf_pkg::SRC_T2: op_b = t2_q;
      default:         op_b = '0;
    endcase
  end

  assign mag_a = skf_pkg::mag(op_a);
  assign mag_b = skf_pkg::mag(op_b);

  // saturating add / subtract
  always_comb begin
    if (cmd_i.uop.op == skf_pkg::OP_SUB) begin
      alu_sum = skf_pkg::SUM_W'(op_a) - skf_pkg::SUM_W'(op_b);
    end else begin
      alu_sum = skf_pkg::SUM_W'(op_a) + skf_pkg::SUM_W'(op_b);
    end
    alu_res = skf_pkg::add_sat(alu_sum);
  end

  // scale and saturate the registered product and the quotient
  assign mul_res = skf_pkg::from_mag(prod_neg_q, prod_q[skf_pkg::PROD_W-1:skf_pkg::FRAC_W]);
  assign div_res = den_pos_q ? skf_pkg::from_mag(div_neg_q, dvd_q) : '0;

  // one restoring division step
  assign div_tr   = {rem_q, dvd_q[skf_pkg::MAG_W-1]};
  assign div_diff = div_tr - {1'b0, den_q};
  assign div_ge   = (div_tr >= {1'b0, den_q});

  // pick the write-back value
  assign is_alu = (cmd_i.uop.op == skf_pkg::OP_ADD) || (cmd_i.uop.op == skf_pkg::OP_SUB);
  assign wb_en  = (cmd_i.issue && is_alu) || cmd_i.mul_wb || cmd_i.div_wb;

  always_comb begin
    priority if (cmd_i.mul_wb) begin
      wb_raw = mul_res;
    end else if (cmd_i.div_wb) begin
      wb_raw = div_res;
    end else begin
      wb_raw = alu_res;
    end
    wb_val = (cmd_i.uop.clamp && wb_raw.val[skf_pkg::DATA_W-1]) ? '0 : wb_raw.val;
  end

  // working registers, multiplier and divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      u_q <= control_in_i;
      z_q <= measurement_i;
    end
    if (cmd_i.issue && (cmd_i.uop.op == skf_pkg::OP_MUL)) begin
      prod_q     <= {{skf_pkg::DATA_W{1'b0}}, mag_a} * {{skf_pkg::DATA_W{1'b0}}, mag_b};
      prod_neg_q <= op_a[skf_pkg::DATA_W-1] ^ op_b[skf_pkg::DATA_W-1];
    end
    if (cmd_i.issue && (cmd_i.uop.op == skf_pkg::OP_DIV)) begin
      dvd_q     <= {mag_a, {skf_pkg::FRAC_W{1'b0}}};
      rem_q     <= '0;
      den_q     <= op_b;
      den_pos_q <= !op_b[skf_pkg::DATA_W-1] && (|op_b);
      div_neg_q <= op_a[skf_pkg::DATA_W-1];
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[skf_pkg::DATA_W-1:0] : div_tr[skf_pkg::DATA_W-1:0];
      dvd_q <= {dvd_q[skf_pkg::MAG_W-2:0], div_ge};
    end
    if (wb_en) begin
      unique case (cmd_i.uop.dst)
        skf_pkg::DST_T1: t1_q <= wb_val;
        skf_pkg::DST_T2: t2_q <= wb_val;
        skf_pkg::DST_MP: mp_q <= wb_val;
        skf_pkg::DST_PP: pp_q <= wb_val;
        skf_pkg::DST_HP: hp_q <= wb_val;
        skf_pkg::DST_K:  k_q  <= wb_val;
        skf_pkg::DST_MN: mn_q <= wb_val;
        skf_pkg::DST_PN: pn_q <= wb_val;
        default: ;
      endcase
    end
  end

  // configuration, filter state, divider count and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= skf_pkg::RST_STATE_GAIN;
      b_q         <= '0;
      h_q         <= skf_pkg::RST_OBSERVE_GAIN;
      q_q         <= '0;
      r_q         <= '0;
      init_mean_q <= '0;
      init_var_q  <= '0;
      mean_q      <= '0;
      var_q       <= '0;
      div_cnt_q   <= '0;
      sat_q       <= 1'b0;
      sat_out_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          skf_pkg::REG_STATE_GAIN:    a_q <= cfg_data_i;
          skf_pkg::REG_CONTROL_GAIN:  b_q <= cfg_data_i;
          skf_pkg::REG_OBSERVE_GAIN:  h_q <= cfg_data_i;
          skf_pkg::REG_PROCESS_NOISE: q_q <= cfg_data_i[skf_pkg::VAR_W-1:0];
          skf_pkg::REG_MEASURE_NOISE: r_q <= cfg_data_i[skf_pkg::VAR_W-1:0];
          skf_pkg::REG_INIT_MEAN: begin
            init_mean_q <= cfg_data_i;
            mean_q      <= cfg_data_i;
            var_q       <= skf_pkg::word_t'({1'b0, init_var_q});
          end
          skf_pkg::REG_INIT_VARIANCE: begin
            init_var_q <= cfg_data_i[skf_pkg::VAR_W-1:0];
            mean_q     <= init_mean_q;
            var_q      <= skf_pkg::word_t'({1'b0, cfg_data_i[skf_pkg::VAR_W-1:0]});
          end
          default: ;
        endcase
      end else if (cmd_i.commit) begin
        mean_q    <= mn_q;
        var_q     <= pn_q;
        sat_out_q <= sat_q;
      end

      // count divider steps
      if (cmd_i.issue && (cmd_i.uop.op == skf_pkg::OP_DIV)) begin
        div_cnt_q <= skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS);
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - skf_pkg::DIV_CNT_W'(1);
      end

      // collect saturation over one step
      if (cmd_i.start) begin
        sat_q <= 1'b0;
      end else if (wb_en) begin
        sat_q <= sat_q | wb_raw.flag;
      end
    end
  end

  assign stat_o.div_last = (div_cnt_q == skf_pkg::DIV_CNT_W'(1));

  assign est_mean_o     = mean_q;
  assign est_variance_o = var_q[skf_pkg::VAR_W-1:0];
  assign saturated_o    = sat_out_q;

endmodule

@@ rtl/core/skf_ctrl.sv @@
// ---------------------------------------------------------------------------
// skf_ctrl
// Sequencer for one filter step: walks the micro-op list, times the
// multiplier and divider, and owns the input and result handshakes.
// ---------------------------------------------------------------------------
module skf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  skf_pkg::dp_stat_t  stat_i,
  output skf_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_EXEC    = 6'b000010,
    ST_MUL_WB  = 6'b000100,
    ST_DIV_RUN = 6'b001000,
    ST_DIV_WB  = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  logic [skf_pkg::STEP_W-1:0]   step_q, step_d;
  logic                         out_valid_q, out_valid_d;
  skf_pkg::uop_t                uop;
  logic                         adv;

  assign uop = skf_pkg::uop_at(step_q);

  // next state and commands
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    adv           = 1'b0;
    cmd_o         = '0;
    cmd_o.uop     = uop;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          step_d      = '0;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.issue = 1'b1;
        unique case (uop.op)
          skf_pkg::OP_MUL: state_d = ST_MUL_WB;
          skf_pkg::OP_DIV: state_d = ST_DIV_RUN;
          skf_pkg::OP_ADD,
          skf_pkg::OP_SUB: adv = 1'b1;
          default:         adv = 1'b1;
        endcase
      end
      ST_MUL_WB: begin
        cmd_o.mul_wb = 1'b1;
        adv          = 1'b1;
      end
      ST_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DIV_WB;
        end
      end
      ST_DIV_WB: begin
        cmd_o.div_wb = 1'b1;
        adv          = 1'b1;
      end
      ST_DONE: begin
        // hold until the result slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // advance to the next micro-op
    if (adv) begin
      step_d  = skf_pkg::STEP_W'(step_q + 1'b1);
      state_d = uop.last ? ST_DONE : ST_EXEC;
    end
  end

  // result beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/scalar_kalman_filter.sv @@
// ---------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter in signed Q16.16 with saturating arithmetic.
//
// Channels: step_i takes one beat per filter step (control value and
// observation); est_o returns one beat per step (updated mean, variance and
// a flag set when any intermediate value saturated); cfg_i writes the seven
// coefficient and initial-state registers and is always ready.
// Flow: the result beat is valid once the whole micro-op sequence has run
// and the step has committed; the next input beat is taken only after that,
// so one item is finished before the next is taken. The sequence runs the
// 48-step restoring divider for the gain and ten passes through the single shared multiplier.
// Reset loads the default coefficients and the initial mean and variance;
// a write to either initial-state register reloads both into the filter.
// A stalled receiver holds the result beat; the next item may already be
// taken and computed, and it waits for the result slot before it commits.
// ---------------------------------------------------------------------------
module scalar_kalman_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  skf_in_if.sink        step_i,
  skf_out_if.source     est_o,
  skf_cfg_if.sink       cfg_i
);

  skf_pkg::dp_cmd_t   cmd;
  skf_pkg::dp_stat_t  stat;

  assign cfg_i.ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (step_i.valid),
    .in_ready_o  (step_i.ready),
    .out_valid_o (est_o.valid),
    .out_ready_i (est_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  skf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .control_in_i   (step_i.control_in),
    .measurement_i  (step_i.measurement),
    .est_mean_o     (est_o.est_mean),
    .est_variance_o (est_o.est_variance),
    .saturated_o    (est_o.saturated)
  );

endmodule
